FILE: rtl/sab_pkg.sv
// ----------------------------------------------------------------------------
// sab_pkg
// Shared types, constants and sequencer states for the suffix array and
// common prefix builder.
// ----------------------------------------------------------------------------
package sab_pkg;

  localparam int CHAR_W       = 8;
  localparam int FIELD_W      = 6;
  localparam int RESULT_CAP   = 64;
  localparam int MAX_LEN_DEF  = 64;
  localparam int ALPHABET_DEF = 256;

  // one text byte per item
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_text;
  } sab_in_t;

  // one sorted rank per item
  typedef struct packed {
    logic [FIELD_W-1:0] rank_index;
    logic [FIELD_W-1:0] suffix_start;
    logic [FIELD_W-1:0] common_prefix;
    logic               truncated;
    logic               last_result;
  } sab_out_t;

  // build sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SENT,
    ST_CLR,
    ST_CNT,
    ST_PFX,
    ST_DIST,
    ST_OCPY,
    ST_CLS,
    ST_CCPY,
    ST_RANK,
    ST_KAS,
    ST_OUT
  } sab_state_t;

endpackage

FILE: rtl/sab_ram.sv
// ----------------------------------------------------------------------------
// sab_ram
// Generic memory: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module sab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: rtl/sab_core.sv
// ----------------------------------------------------------------------------
// sab_core
// Build sequencer: prefix doubling with counting sort, then the common
// prefix walk, then rank-ordered readout. All work goes through the stores
// one access step at a time.
// ----------------------------------------------------------------------------
module sab_core import sab_pkg::*; #(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           text_we,
  input  logic [$clog2(MAX_LEN+1)-1:0]   text_waddr,
  input  logic [CHAR_W-1:0]              text_wdata,
  input  logic                           start,
  input  logic [$clog2(MAX_LEN+2)-1:0]   start_len,
  output logic                           idle,
  output logic                           res_valid,
  output sab_out_t                       res,
  input  logic                           res_take
);

  localparam int SLOTS = MAX_LEN + 1;
  localparam int AW    = $clog2(SLOTS);
  localparam int NW    = $clog2(MAX_LEN + 2);
  localparam int BD    = (ALPHABET > SLOTS) ? ALPHABET : SLOTS;
  localparam int BW    = $clog2(BD);
  localparam int IW    = $clog2(BD + 1);
  localparam int LW    = NW + 1;

  sab_state_t state, state_next;
  logic [2:0]    ph;
  logic [IW-1:0] idx;
  logic          first;
  logic [LW-1:0] lstep;
  logic [NW-1:0] n, len, acc, h;
  logic [BW-1:0] key, pk1;
  logic [AW-1:0] jr, ar, pk2, pc, rr, tp;

  // store ports
  logic              t_we, o_we, no_we, c_we, nc_we, b_we, rk_we, p_we;
  logic [AW-1:0]     t_wa, o_wa, no_wa, c_wa, nc_wa, rk_wa, p_wa;
  logic [BW-1:0]     b_wa, b_ra;
  logic [CHAR_W-1:0] t_wd, t_qa, t_qb;
  logic [AW-1:0]     o_wd, no_wd, c_wd, nc_wd, rk_wd, p_wd;
  logic [NW-1:0]     b_wd, b_qa;
  logic [AW-1:0]     t_ra, t_rb, o_ra, no_ra, c_ra, c_rb, nc_ra, rk_ra, p_ra;
  logic [AW-1:0]     o_qa, no_qa, c_qa, c_qb, nc_qa, rk_qa, p_qa;

  // helpers
  logic [IW-1:0] lim;
  logic          last_lim, last_n, last_len, kas_adv, out_last, r_last;
  logic          in_range, same_char, differ;
  logic [AW-1:0] ia, j_now, b_sh, cls_new, tp_now;
  logic [LW-1:0] sj, sb;
  logic [BW-1:0] k_now;
  logic [NW-1:0] acc_sum, h_dec, cnt;

  assign ia       = idx[AW-1:0];
  assign lim      = first ? IW'(ALPHABET) : IW'(n);
  assign last_lim = (idx == lim - 1'b1);
  assign last_n   = (idx == IW'(n) - 1'b1);
  assign last_len = (idx == IW'(len) - 1'b1);
  assign cnt      = (int'(len) < RESULT_CAP) ? len : NW'(RESULT_CAP);
  assign out_last = (idx == IW'(cnt) - 1'b1);

  // cyclic shifts by the current doubling step
  assign sj    = LW'(o_qa) + LW'(n) - lstep;
  assign j_now = first ? ia : ((sj >= LW'(n)) ? AW'(sj - LW'(n)) : AW'(sj));
  assign sb    = LW'(o_qa) + lstep;
  assign b_sh  = (sb >= LW'(n)) ? AW'(sb - LW'(n)) : AW'(sb);

  // sort key of the current element
  assign k_now   = first ? BW'(t_qa) : BW'(c_qa);
  assign differ  = (k_now != pk1) || (!first && (c_qb != pk2));
  assign cls_new = (idx == '0) ? '0 : (pc + AW'(differ));
  assign acc_sum = acc + b_qa;

  // common prefix walk
  assign r_last    = (NW'(rk_qa) == len - 1'b1);
  assign tp_now    = (ia > o_qa) ? ia : o_qa;
  assign in_range  = ((LW'(tp) + LW'(h)) < LW'(len));
  assign same_char = (t_qa == t_qb);
  assign h_dec     = (h != '0) ? (h - 1'b1) : '0;
  assign kas_adv   = ((ph == 3'd1) && r_last) || ((ph == 3'd3) && !in_range) ||
                     ((ph == 3'd4) && !same_char);

  assign idle = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_SENT;
      ST_SENT: state_next = ST_CLR;
      ST_CLR:  if (last_lim) state_next = ST_CNT;
      ST_CNT:  if (ph == 3'd2 && last_n) state_next = ST_PFX;
      ST_PFX:  if (ph == 3'd1 && last_lim) state_next = ST_DIST;
      ST_DIST: if (ph == 3'd3 && idx == '0) state_next = first ? ST_CLS : ST_OCPY;
      ST_OCPY: if (ph == 3'd1 && last_n) state_next = ST_CLS;
      ST_CLS:  if (ph == 3'd2 && last_n) state_next = first ? ST_CLR : ST_CCPY;
      ST_CCPY: begin
        if (ph == 3'd1 && last_n) begin
          state_next = ((lstep << 1) < LW'(n)) ? ST_CLR : ST_RANK;
        end
      end
      ST_RANK: if (ph == 3'd1 && last_len) state_next = ST_KAS;
      ST_KAS:  if (kas_adv && last_len) state_next = ST_OUT;
      ST_OUT:  if (ph == 3'd1 && res_take && out_last) state_next = ST_IDLE;
    endcase
  end

  // store access per step
  always_comb begin
    t_we = 1'b0;  t_wa = '0;  t_wd = '0;  t_ra = '0;  t_rb = '0;
    o_we = 1'b0;  o_wa = '0;  o_wd = '0;  o_ra = '0;
    no_we = 1'b0; no_wa = '0; no_wd = '0; no_ra = '0;
    c_we = 1'b0;  c_wa = '0;  c_wd = '0;  c_ra = '0;  c_rb = '0;
    nc_we = 1'b0; nc_wa = '0; nc_wd = '0; nc_ra = '0;
    b_we = 1'b0;  b_wa = '0;  b_wd = '0;  b_ra = '0;
    rk_we = 1'b0; rk_wa = '0; rk_wd = '0; rk_ra = '0;
    p_we = 1'b0;  p_wa = '0;  p_wd = '0;  p_ra = '0;
    res_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        t_we = text_we;
        t_wa = text_waddr;
        t_wd = text_wdata;
      end
      ST_SENT: begin
        t_we = 1'b1;
        t_wa = AW'(len);
      end
      ST_CLR: begin
        b_we = 1'b1;
        b_wa = idx[BW-1:0];
      end
      ST_CNT: begin
        if (ph == 3'd0) begin
          t_ra = ia;
          c_ra = ia;
        end else if (ph == 3'd1) begin
          b_ra = k_now;
        end else begin
          b_we = 1'b1;
          b_wa = key;
          b_wd = b_qa + 1'b1;
        end
      end
      ST_PFX: begin
        b_ra = idx[BW-1:0];
        if (ph == 3'd1) begin
          b_we = 1'b1;
          b_wa = idx[BW-1:0];
          b_wd = acc_sum;
        end
      end
      ST_DIST: begin
        if (ph == 3'd0) begin
          o_ra = ia;
        end else if (ph == 3'd1) begin
          t_ra = j_now;
          c_ra = j_now;
        end else if (ph == 3'd2) begin
          b_ra = k_now;
        end else begin
          b_we  = 1'b1;
          b_wa  = key;
          b_wd  = b_qa - 1'b1;
          o_we  = first;
          o_wa  = AW'(b_qa - 1'b1);
          o_wd  = jr;
          no_we = !first;
          no_wa = AW'(b_qa - 1'b1);
          no_wd = jr;
        end
      end
      ST_OCPY: begin
        no_ra = ia;
        if (ph == 3'd1) begin
          o_we = 1'b1;
          o_wa = ia;
          o_wd = no_qa;
        end
      end
      ST_CLS: begin
        if (ph == 3'd0) begin
          o_ra = ia;
        end else if (ph == 3'd1) begin
          t_ra = o_qa;
          c_ra = o_qa;
          c_rb = b_sh;
        end else begin
          c_we  = first;
          c_wa  = ar;
          c_wd  = cls_new;
          nc_we = !first;
          nc_wa = ar;
          nc_wd = cls_new;
        end
      end
      ST_CCPY: begin
        nc_ra = ia;
        if (ph == 3'd1) begin
          c_we = 1'b1;
          c_wa = ia;
          c_wd = nc_qa;
        end
      end
      ST_RANK: begin
        o_ra = ia + 1'b1;
        if (ph == 3'd1) begin
          rk_we = 1'b1;
          rk_wa = o_qa;
          rk_wd = ia;
        end
      end
      ST_KAS: begin
        rk_ra = ia;
        if (ph == 3'd1) begin
          if (r_last) begin
            p_we = 1'b1;
            p_wa = rk_qa;
          end else begin
            o_ra = rk_qa + AW'(2);
          end
        end else if (ph == 3'd3) begin
          t_ra = ia + h[AW-1:0];
          t_rb = jr + h[AW-1:0];
          if (!in_range) begin
            p_we = 1'b1;
            p_wa = rr;
            p_wd = h[AW-1:0];
          end
        end else if (ph == 3'd4) begin
          if (!same_char) begin
            p_we = 1'b1;
            p_wa = rr;
            p_wd = h[AW-1:0];
          end
        end
      end
      ST_OUT: begin
        o_ra      = ia + 1'b1;
        p_ra      = ia;
        res_valid = (ph == 3'd1);
      end
    endcase
  end

  assign res.rank_index    = FIELD_W'(idx);
  assign res.suffix_start  = FIELD_W'(o_qa);
  assign res.common_prefix = FIELD_W'(p_qa);
  assign res.truncated     = 1'b0;
  assign res.last_result   = out_last;

  // sequencer control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ph    <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE, ST_SENT: begin
          ph  <= '0;
          idx <= '0;
        end
        ST_CLR: idx <= last_lim ? '0 : idx + 1'b1;
        ST_CNT: begin
          if (ph == 3'd2) begin
            ph  <= '0;
            idx <= last_n ? '0 : idx + 1'b1;
          end else begin
            ph <= ph + 1'b1;
          end
        end
        ST_PFX: begin
          if (ph == 3'd1) begin
            ph  <= '0;
            idx <= last_lim ? IW'(n) - 1'b1 : idx + 1'b1;
          end else begin
            ph <= 3'd1;
          end
        end
        ST_DIST: begin
          if (ph == 3'd3) begin
            ph  <= '0;
            idx <= (idx == '0) ? '0 : idx - 1'b1;
          end else begin
            ph <= ph + 1'b1;
          end
        end
        ST_OCPY, ST_CCPY: begin
          if (ph == 3'd1) begin
            ph  <= '0;
            idx <= last_n ? '0 : idx + 1'b1;
          end else begin
            ph <= 3'd1;
          end
        end
        ST_CLS: begin
          if (ph == 3'd2) begin
            ph  <= '0;
            idx <= last_n ? '0 : idx + 1'b1;
          end else begin
            ph <= ph + 1'b1;
          end
        end
        ST_RANK: begin
          if (ph == 3'd1) begin
            ph  <= '0;
            idx <= last_len ? '0 : idx + 1'b1;
          end else begin
            ph <= 3'd1;
          end
        end
        ST_KAS: begin
          if (kas_adv) begin
            ph  <= '0;
            idx <= last_len ? '0 : idx + 1'b1;
          end else if (ph == 3'd4) begin
            ph <= 3'd3;
          end else begin
            ph <= ph + 1'b1;
          end
        end
        ST_OUT: begin
          if (ph == 3'd0) begin
            ph <= 3'd1;
          end else if (res_take) begin
            ph  <= '0;
            idx <= out_last ? '0 : idx + 1'b1;
          end
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (start) len <= start_len;
      ST_SENT: begin
        n     <= len + 1'b1;
        first <= 1'b1;
        lstep <= LW'(1);
      end
      ST_CNT: begin
        if (ph == 3'd1) key <= k_now;
        acc <= '0;
      end
      ST_PFX: if (ph == 3'd1) acc <= acc_sum;
      ST_DIST: begin
        if (ph == 3'd1) jr <= j_now;
        if (ph == 3'd2) key <= k_now;
      end
      ST_CLS: begin
        if (ph == 3'd1) ar <= o_qa;
        if (ph == 3'd2) begin
          pk1 <= k_now;
          pk2 <= c_qb;
          pc  <= cls_new;
          if (last_n) first <= 1'b0;
        end
      end
      ST_CCPY: if (ph == 3'd1 && last_n) lstep <= lstep << 1;
      ST_RANK: h <= '0;
      ST_KAS: begin
        if (ph == 3'd1) begin
          rr <= rk_qa;
          if (r_last) h <= '0;
        end else if (ph == 3'd2) begin
          jr <= o_qa;
          tp <= tp_now;
        end else if (ph == 3'd3) begin
          if (!in_range) h <= h_dec;
        end else if (ph == 3'd4) begin
          h <= same_char ? h + 1'b1 : h_dec;
        end
      end
      ST_CLR, ST_OCPY, ST_OUT: begin
      end
    endcase
  end

  // stores
  sab_ram #(.WIDTH(CHAR_W), .DEPTH(SLOTS)) u_text (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd),
    .raddr_a(t_ra), .raddr_b(t_rb), .rdata_a(t_qa), .rdata_b(t_qb)
  );
  sab_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_order (
    .clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd),
    .raddr_a(o_ra), .raddr_b('0), .rdata_a(o_qa), .rdata_b()
  );
  sab_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_next_order (
    .clk(clk), .we(no_we), .waddr(no_wa), .wdata(no_wd),
    .raddr_a(no_ra), .raddr_b('0), .rdata_a(no_qa), .rdata_b()
  );
  sab_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_class (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd),
    .raddr_a(c_ra), .raddr_b(c_rb), .rdata_a(c_qa), .rdata_b(c_qb)
  );
  sab_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_next_class (
    .clk(clk), .we(nc_we), .waddr(nc_wa), .wdata(nc_wd),
    .raddr_a(nc_ra), .raddr_b('0), .rdata_a(nc_qa), .rdata_b()
  );
  sab_ram #(.WIDTH(NW), .DEPTH(BD)) u_buckets (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd),
    .raddr_a(b_ra), .raddr_b('0), .rdata_a(b_qa), .rdata_b()
  );
  sab_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_rank (
    .clk(clk), .we(rk_we), .waddr(rk_wa), .wdata(rk_wd),
    .raddr_a(rk_ra), .raddr_b('0), .rdata_a(rk_qa), .rdata_b()
  );
  sab_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_prefix (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd),
    .raddr_a(p_ra), .raddr_b('0), .rdata_a(p_qa), .rdata_b()
  );

  // a bucket is never empty when an element is placed from it
  a_bucket_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIST && ph == 3'd3) |-> (b_qa != '0))
    else $error("bucket underflow during placement");

  // the carried prefix length stays below the text length
  a_prefix_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KAS) |-> (h < len))
    else $error("common prefix length out of range");

  // a doubling pass only starts with a step shorter than the text plus its sentinel
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLR && !first) |-> (lstep < LW'(n)))
    else $error("doubling step out of range");

  // an offered result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_take) |=> (res_valid && $stable(res)))
    else $error("offered result changed before take");

endmodule

FILE: rtl/suffix_array_lcp_builder_unit.sv
// ----------------------------------------------------------------------------
// suffix_array_lcp_builder_unit
// Collects a text one byte per item, then emits its suffix array with the
// common prefix length to the next-ranked suffix, one rank per item.
// ----------------------------------------------------------------------------
// Bytes load one per cycle while char_stall is low. The item with
// end_of_text starts the build, and char_stall stays high until the last
// rank has been handed to the output register. The build works through
// the stores one access step at a time: a character pass, ceil(log2 n)
// doubling passes, then ranking and the prefix walk, and then the
// results, with n the text length plus one. Characters beyond MAX_LEN
// are dropped and flagged as truncated on every result of the run; an
// end_of_text with no stored characters gives no results.
module suffix_array_lcp_builder_unit import sab_pkg::*; #(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     char_valid,
  output logic     char_stall,
  input  sab_in_t  char_item,
  output logic     result_valid,
  input  logic     result_stall,
  output sab_out_t result_item
);

  localparam int AW = $clog2(MAX_LEN + 1);
  localparam int NW = $clog2(MAX_LEN + 2);

  logic [NW-1:0]     len, len_fin;
  logic              ovf;
  logic              accept, store, drop, start, room, core_idle;
  logic [CHAR_W-1:0] code;
  logic              res_valid, load;
  sab_out_t          res;

  // input side
  assign char_stall = !core_idle;
  assign accept     = char_valid && !char_stall;
  assign code       = (int'(char_item.char_code) >= ALPHABET) ?
                      CHAR_W'(ALPHABET - 1) : char_item.char_code;
  assign room       = (int'(len) < MAX_LEN);
  assign store      = accept && (char_item.char_code != '0) && room;
  assign drop       = accept && (char_item.char_code != '0) && !room;
  assign len_fin    = len + NW'(store);
  assign start      = accept && char_item.end_of_text && (len_fin != '0);

  // output register
  assign load = res_valid && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      len          <= '0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        len <= char_item.end_of_text ? '0 : len_fin;
      end
      priority if (load && res.last_result) begin
        ovf <= 1'b0;
      end else if (accept && char_item.end_of_text && len_fin == '0) begin
        ovf <= 1'b0;
      end else if (drop) begin
        ovf <= 1'b1;
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      result_item <= '{rank_index:    res.rank_index,
                       suffix_start:  res.suffix_start,
                       common_prefix: res.common_prefix,
                       truncated:     ovf,
                       last_result:   res.last_result};
    end
  end

  sab_core #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_core (
    .clk       (clk),
    .rst       (rst),
    .text_we   (store),
    .text_waddr(len[AW-1:0]),
    .text_wdata(code),
    .start     (start),
    .start_len (len_fin),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (load)
  );

endmodule

FILE: test/suffix_array_lcp_builder_unit_test.sv
// ----------------------------------------------------------------------------
// suffix_array_lcp_builder_unit_test
// Sends short texts one byte per item with random gaps and output stalls,
// predicts the sorted suffixes and common prefix lengths, and checks every
// result item against the prediction.
// ----------------------------------------------------------------------------
module suffix_array_lcp_builder_unit_test
  import sab_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEXT_CAP = MAX_LEN_DEF;

  logic     clk;
  logic     rst;
  logic     char_valid;
  logic     char_stall;
  sab_in_t  char_item;
  logic     result_valid;
  logic     result_stall;
  sab_out_t result_item;

  int error_count = 0;
  bit quiet_mode = 0;

  suffix_array_lcp_builder_unit i_dut (
    .clk(clk), .rst(rst),
    .char_valid(char_valid), .char_stall(char_stall), .char_item(char_item),
    .result_valid(result_valid), .result_stall(result_stall),
    .result_item(result_item)
  );

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // collects the text and predicts the ranks at end of text
  class SuffixScoreboard;
    byte unsigned text_buf[$];
    bit           dropped;
    sab_out_t     pending_ranks[$];

    // suffix compare with the implicit zero sentinel
    function automatic bit suffix_less(int a, int b);
      int n;
      n = text_buf.size();
      while (a < n && b < n) begin
        if (text_buf[a] != text_buf[b]) return text_buf[a] < text_buf[b];
        a++;
        b++;
      end
      return a >= n;
    endfunction

    function automatic void note_char(sab_in_t it);
      int n;
      int order[$];
      int lcp;
      int pos;
      sab_out_t r;
      if (it.char_code != 0) begin
        if (text_buf.size() < TEXT_CAP) text_buf.insert(text_buf.size(), it.char_code);
        else dropped = 1;
      end
      if (!it.end_of_text) return;
      n = text_buf.size();
      // insertion sort of suffix starts
      for (int i = 0; i < n; i++) begin
        pos = order.size();
        while (pos > 0 && suffix_less(i, order[pos-1])) pos--;
        order.insert(pos, i);
      end
      for (int rk = 0; rk < n; rk++) begin
        lcp = 0;
        if (rk < n - 1)
          while (order[rk] + lcp < n && order[rk+1] + lcp < n &&
                 text_buf[order[rk]+lcp] == text_buf[order[rk+1]+lcp]) lcp++;
        r.rank_index    = 6'(rk);
        r.suffix_start  = 6'(order[rk]);
        r.common_prefix = 6'(lcp);
        r.truncated     = dropped;
        r.last_result   = (rk == n - 1);
        pending_ranks.insert(pending_ranks.size(), r);
      end
      text_buf.delete();
      dropped = 0;
    endfunction

    task automatic check_rank(sab_out_t got);
      sab_out_t exp;
      if (pending_ranks.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", got));
        return;
      end
      exp = pending_ranks.pop_front();
      if (got.rank_index != exp.rank_index)
        report_mismatch($sformatf("rank_index %0d exp %0d", got.rank_index, exp.rank_index));
      if (got.suffix_start != exp.suffix_start)
        report_mismatch($sformatf("suffix_start %0d exp %0d rank %0d",
                                  got.suffix_start, exp.suffix_start, exp.rank_index));
      if (got.common_prefix != exp.common_prefix)
        report_mismatch($sformatf("common_prefix %0d exp %0d rank %0d",
                                  got.common_prefix, exp.common_prefix, exp.rank_index));
      if (got.truncated != exp.truncated)
        report_mismatch($sformatf("truncated %0d exp %0d", got.truncated, exp.truncated));
      if (got.last_result != exp.last_result)
        report_mismatch($sformatf("last_result %0d exp %0d", got.last_result,
                                  exp.last_result));
    endtask
  endclass

  SuffixScoreboard rank_board = new();

  // clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    #40ms;
    $display("Verification failed");
    $finish;
  end

  // output side: random stall bursts, check on accept
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) rank_board.check_rank(result_item);
  end

  initial begin
    int burst;
    result_stall = 0;
    forever begin
      @(negedge clk);
      if (burst > 0) begin
        burst--;
        result_stall <= 1;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 4) - 1;
        result_stall <= 1;
      end else result_stall <= 0;
    end
  end

  // send one item, with an optional idle burst first
  task automatic send_char(input logic [7:0] code, input bit eot);
    sab_in_t it;
    if (!quiet_mode && $urandom_range(0, 4) == 0) begin
      char_valid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    it.char_code   = code;
    it.end_of_text = eot;
    char_item  <= it;
    char_valid <= 1;
    do @(posedge clk); while (char_stall);
    rank_board.note_char(it);
    @(negedge clk);
  endtask

  task automatic send_text(input int len, input int lo, input int hi);
    for (int i = 0; i < len; i++)
      send_char(8'($urandom_range(lo, hi)), i == len - 1);
  endtask

  initial begin
    int cnt;
    int len;
    rst = 1;
    char_valid = 0;
    char_item = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: extremes, zero code, empty text, repeats
    send_char(8'd1, 0); send_char(8'd255, 0); send_char(8'd128, 1);
    send_char(8'd0, 1);                          // empty text
    send_char(8'd0, 0); send_char(8'd7, 0); send_char(8'd0, 1);
    send_char(8'd85, 1);                         // single char
    send_text(6, 97, 97);                        // all equal
    send_char(8'd170, 0); send_char(8'd85, 0); send_char(8'd170, 0);
    send_char(8'd85, 1);
    // full text with overflow
    for (int i = 0; i < TEXT_CAP + 3; i++) send_char(8'($urandom_range(1, 2)), 0);
    send_char(8'd255, 1);
    send_text(TEXT_CAP, 1, 255);                 // exactly full

    // random texts, mostly small alphabets to get long repeats
    cnt = 0;
    while (cnt < 80) begin
      if (cnt > 50) quiet_mode = 1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0: send_text(len, 1, 2);
        1: send_text(len, 1, 4);
        2: send_text(len, 1, 255);
        default: begin
          for (int i = 0; i < len; i++)
            send_char(($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(250, 255)),
                      i == len - 1);
        end
      endcase
      cnt += len;
    end
    char_valid <= 0;

    while (rank_board.pending_ranks.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
